[sv/bbfe_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bbfe_pkg
// Shared constants for the byte buffer field engine: store geometry,
// position widths and operation codes.
// ----------------------------------------------------------------------------
package bbfe_pkg;

  // store geometry
  localparam int BUF_BYTES = 4096;
  localparam int ADDR_W    = $clog2(BUF_BYTES);
  localparam int POS_W     = ADDR_W + 1;

  // widest bit field
  localparam int FIELD_MAX_BITS = 32;

  // operation codes
  localparam logic [2:0] OP_CLEAR    = 3'd0;
  localparam logic [2:0] OP_SEEK     = 3'd1;
  localparam logic [2:0] OP_PUT      = 3'd2;
  localparam logic [2:0] OP_GET      = 3'd3;
  localparam logic [2:0] OP_FILL     = 3'd4;
  localparam logic [2:0] OP_PUT_BITS = 3'd5;
  localparam logic [2:0] OP_GET_BITS = 3'd6;

endpackage

[sv/bbfe_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bbfe_ram
// Single-port synchronous RAM, read-first, with registered read data.
// ----------------------------------------------------------------------------
module bbfe_ram #(
  parameter int ADDR_W = 12,
  parameter int DATA_W = 8
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] addr,
  input  logic [DATA_W-1:0] wdata,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [2**ADDR_W];

  // write and registered read on one port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

[sv/byte_buffer_field_engine_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// byte_buffer_field_engine_top
// Byte store with cursor and high-water mark: clear, seek, put/get of
// 1/2/4/8 bytes, zero fill, bit-field insert and extract.
//
// Usage:
//   Input words (in_*) carry one operation each and are taken when in_valid
//   is high and in_stall is low. Every word yields exactly one result word
//   on out_* (ok flag, read value, cursor, mark), taken when out_valid is
//   high and out_stall is low. cfg_wr_en/cfg_wr_data set the byte order
//   (1 = big endian) and may be written while no operation is in flight.
//   All store traffic goes through the one byte-wide RAM port: put, get
//   and zero fill move one byte at a time; a bit-field operation reads
//   the bytes its field spans (up to 5) and, for a put, writes them back.
//   One operation is worked on at a time; the next word is taken once the
//   result sits in the output register, even if the receiver is stalling.
//   A stalled result holds the engine in its final step until taken.
//   Reset: after rst_n the store is swept to zero, one byte per cycle,
//   all 4096 bytes, with in_stall high; cursor, mark and byte order clear.
// ----------------------------------------------------------------------------
module byte_buffer_field_engine_top (
  input  logic                  clk,
  input  logic                  rst_n,
  // configuration
  input  logic                  cfg_wr_en,
  input  logic                  cfg_wr_data,
  // operation input
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [2:0]            in_operation,
  input  logic [1:0]            in_size_code,
  input  logic [63:0]           in_data_value,
  input  logic [15:0]           in_new_position,
  input  logic [15:0]           in_fill_count,
  input  logic [15:0]           in_bit_offset,
  input  logic [5:0]            in_bit_width,
  // result output
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  out_ok,
  output logic [63:0]           out_read_value,
  output logic [bbfe_pkg::POS_W-1:0] out_cursor,
  output logic [bbfe_pkg::POS_W-1:0] out_high_mark
);

  import bbfe_pkg::*;

  typedef enum logic [3:0] {
    S_WIPE, S_IDLE, S_PUT, S_GET, S_FILL, S_BRD, S_BMOD, S_BWR, S_FIN
  } state_t;

  state_t            state_r, state_nxt;
  logic [POS_W-1:0]  cur_r, cur_nxt;
  logic [POS_W-1:0]  mark_r, mark_nxt;
  logic              be_r, be_nxt;
  logic [2:0]        op_r, op_nxt;
  logic [3:0]        nb_r, nb_nxt;
  logic [63:0]       data_r, data_nxt;
  logic [POS_W-1:0]  idx_r, idx_nxt;
  logic [POS_W-1:0]  lim_r, lim_nxt;
  logic [ADDR_W-1:0] base_r, base_nxt;
  logic              pend_r, pend_nxt;
  logic [2:0]        lane_r, lane_nxt;
  logic [39:0]       acc_r, acc_nxt;
  logic [2:0]        sh_r, sh_nxt;
  logic [31:0]       mask_r, mask_nxt;
  logic              ok_r, ok_nxt;
  logic [63:0]       rv_r, rv_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic              out_ok_r, out_ok_nxt;
  logic [63:0]       out_rv_r, out_rv_nxt;
  logic [POS_W-1:0]  out_cur_r, out_cur_nxt;
  logic [POS_W-1:0]  out_mark_r, out_mark_nxt;

  // store port
  logic              ram_we;
  logic [ADDR_W-1:0] ram_addr;
  logic [7:0]        ram_wdata;
  logic [7:0]        ram_rdata;

  bbfe_ram #(
    .ADDR_W (ADDR_W),
    .DATA_W (8)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  // mark follows the cursor upward
  function automatic logic [POS_W-1:0] raise_mark(input logic [POS_W-1:0] pos,
                                                  input logic [POS_W-1:0] mark);
    raise_mark = (pos > mark) ? pos : mark;
  endfunction

  // decode of the incoming word
  logic [3:0]        n_c;
  logic [POS_W:0]    end_c;
  logic              fits_c;
  logic [POS_W-1:0]  avail_c;
  logic              fill_over_c;
  logic              wid_ok_c;
  logic [16:0]       endbit_c;
  logic [13:0]       last_c;
  logic [12:0]       first_c;
  logic              span_ok_c;
  logic [32:0]       mask_wide_c;
  logic [31:0]       mask_c;
  logic              val_ok_c;
  logic [13:0]       span_diff_c;

  always_comb begin
    n_c         = 4'd1 << in_size_code;
    end_c       = {1'b0, cur_r} + {{(POS_W-3){1'b0}}, n_c};
    fits_c      = end_c <= (POS_W+1)'(BUF_BYTES);
    avail_c     = POS_W'(BUF_BYTES) - cur_r;
    fill_over_c = in_fill_count > 16'(avail_c);
    wid_ok_c    = (in_bit_width != 6'd0) && (in_bit_width <= 6'(FIELD_MAX_BITS));
    endbit_c    = {1'b0, in_bit_offset} + {11'd0, in_bit_width} - 17'd1;
    last_c      = endbit_c[16:3];
    first_c     = in_bit_offset[15:3];
    span_ok_c   = wid_ok_c && (last_c < 14'(mark_r));
    mask_wide_c = (33'd1 << in_bit_width) - 33'd1;
    mask_c      = mask_wide_c[31:0];
    val_ok_c    = (in_data_value[63:32] == 32'd0) &&
                  ((in_data_value[31:0] & ~mask_c) == 32'd0);
    span_diff_c = last_c - {1'b0, first_c};
  end

  // per-step helpers
  logic [3:0]        lane_c;
  logic [63:0]       put_sel_c;
  logic [39:0]       field_c;
  logic [POS_W-1:0]  step_end_c;

  always_comb begin
    lane_c     = be_r ? (nb_r - 4'd1 - idx_r[3:0]) : idx_r[3:0];
    put_sel_c  = data_r >> {lane_c[2:0], 3'b000};
    field_c    = acc_r >> sh_r;
    step_end_c = cur_r + POS_W'(nb_r);
  end

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    cur_nxt       = cur_r;
    mark_nxt      = mark_r;
    be_nxt        = cfg_wr_en ? cfg_wr_data : be_r;
    op_nxt        = op_r;
    nb_nxt        = nb_r;
    data_nxt      = data_r;
    idx_nxt       = idx_r;
    lim_nxt       = lim_r;
    base_nxt      = base_r;
    pend_nxt      = pend_r;
    lane_nxt      = lane_r;
    acc_nxt       = acc_r;
    sh_nxt        = sh_r;
    mask_nxt      = mask_r;
    ok_nxt        = ok_r;
    rv_nxt        = rv_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_ok_nxt    = out_ok_r;
    out_rv_nxt    = out_rv_r;
    out_cur_nxt   = out_cur_r;
    out_mark_nxt  = out_mark_r;
    ram_we        = 1'b0;
    ram_addr      = base_r + idx_r[ADDR_W-1:0];
    ram_wdata     = 8'd0;

    unique case (state_r)
      // zero sweep after reset
      S_WIPE: begin
        ram_we   = 1'b1;
        ram_addr = idx_r[ADDR_W-1:0];
        if (idx_r == POS_W'(BUF_BYTES - 1)) begin
          state_nxt = S_IDLE;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end

      // take a word and set up its steps
      S_IDLE: begin
        if (in_valid) begin
          op_nxt    = in_operation;
          data_nxt  = in_data_value;
          rv_nxt    = 64'd0;
          ok_nxt    = 1'b0;
          idx_nxt   = '0;
          pend_nxt  = 1'b0;
          acc_nxt   = 40'd0;
          state_nxt = S_FIN;
          unique case (in_operation)
            OP_CLEAR: begin
              cur_nxt  = '0;
              mark_nxt = '0;
              ok_nxt   = 1'b1;
            end
            OP_SEEK: begin
              if (in_new_position <= 16'(BUF_BYTES)) begin
                cur_nxt = in_new_position[POS_W-1:0];
                ok_nxt  = 1'b1;
              end
            end
            OP_PUT, OP_GET: begin
              if (fits_c) begin
                nb_nxt    = n_c;
                base_nxt  = cur_r[ADDR_W-1:0];
                state_nxt = (in_operation == OP_PUT) ? S_PUT : S_GET;
              end
            end
            OP_FILL: begin
              ok_nxt    = !fill_over_c;
              lim_nxt   = fill_over_c ? avail_c : in_fill_count[POS_W-1:0];
              base_nxt  = cur_r[ADDR_W-1:0];
              state_nxt = S_FILL;
            end
            OP_PUT_BITS, OP_GET_BITS: begin
              if (span_ok_c && (in_operation == OP_GET_BITS || val_ok_c)) begin
                base_nxt  = first_c[ADDR_W-1:0];
                nb_nxt    = span_diff_c[3:0] + 4'd1;
                sh_nxt    = ~endbit_c[2:0];
                mask_nxt  = mask_c;
                state_nxt = S_BRD;
              end
            end
            default: begin
              // unused code: no change, refused
            end
          endcase
        end
      end

      // one byte written per cycle
      S_PUT: begin
        ram_we    = 1'b1;
        ram_wdata = put_sel_c[7:0];
        if (idx_r[3:0] == nb_r - 4'd1) begin
          cur_nxt   = step_end_c;
          mark_nxt  = raise_mark(step_end_c, mark_r);
          ok_nxt    = 1'b1;
          state_nxt = S_FIN;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end

      // reads issued back to back, each byte merged in the next cycle
      S_GET: begin
        pend_nxt = 1'b0;
        if (idx_r[3:0] < nb_r) begin
          pend_nxt = 1'b1;
          lane_nxt = lane_c[2:0];
          idx_nxt  = idx_r + 1'b1;
        end
        if (pend_r) begin
          rv_nxt = rv_r | ({56'd0, ram_rdata} << {lane_r, 3'b000});
        end
        if (idx_r[3:0] == nb_r && !pend_r) begin
          cur_nxt   = step_end_c;
          ok_nxt    = 1'b1;
          state_nxt = S_FIN;
        end
      end

      // zero bytes up to the limit
      S_FILL: begin
        if (idx_r == lim_r) begin
          cur_nxt   = cur_r + lim_r;
          mark_nxt  = raise_mark(cur_r + lim_r, mark_r);
          state_nxt = S_FIN;
        end else begin
          ram_we  = 1'b1;
          idx_nxt = idx_r + 1'b1;
        end
      end

      // gather field bytes, first byte most significant
      S_BRD: begin
        pend_nxt = 1'b0;
        if (idx_r[3:0] < nb_r) begin
          pend_nxt = 1'b1;
          idx_nxt  = idx_r + 1'b1;
        end
        if (pend_r) begin
          acc_nxt = {acc_r[31:0], ram_rdata};
        end
        if (idx_r[3:0] == nb_r && !pend_r) begin
          state_nxt = S_BMOD;
        end
      end

      // extract, or merge the new field
      S_BMOD: begin
        if (op_r == OP_GET_BITS) begin
          rv_nxt    = {32'd0, field_c[31:0] & mask_r};
          ok_nxt    = 1'b1;
          state_nxt = S_FIN;
        end else begin
          acc_nxt   = (acc_r & ~({8'd0, mask_r} << sh_r)) |
                      ({8'd0, data_r[31:0]} << sh_r);
          idx_nxt   = POS_W'(nb_r - 4'd1);
          state_nxt = S_BWR;
        end
      end

      // write back from the last byte down
      S_BWR: begin
        ram_we    = 1'b1;
        ram_wdata = acc_r[7:0];
        acc_nxt   = acc_r >> 8;
        if (idx_r == '0) begin
          ok_nxt    = 1'b1;
          state_nxt = S_FIN;
        end else begin
          idx_nxt = idx_r - 1'b1;
        end
      end

      // hand the result to the output register
      S_FIN: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_ok_nxt    = ok_r;
          out_rv_nxt    = rv_r;
          out_cur_nxt   = cur_r;
          out_mark_nxt  = mark_r;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_WIPE;
      cur_r       <= '0;
      mark_r      <= '0;
      be_r        <= 1'b0;
      idx_r       <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cur_r       <= cur_nxt;
      mark_r      <= mark_nxt;
      be_r        <= be_nxt;
      idx_r       <= idx_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
    op_r       <= op_nxt;
    nb_r       <= nb_nxt;
    data_r     <= data_nxt;
    lim_r      <= lim_nxt;
    base_r     <= base_nxt;
    lane_r     <= lane_nxt;
    acc_r      <= acc_nxt;
    sh_r       <= sh_nxt;
    mask_r     <= mask_nxt;
    ok_r       <= ok_nxt;
    rv_r       <= rv_nxt;
    out_ok_r   <= out_ok_nxt;
    out_rv_r   <= out_rv_nxt;
    out_cur_r  <= out_cur_nxt;
    out_mark_r <= out_mark_nxt;
  end

  assign in_stall       = (state_r != S_IDLE);
  assign out_valid      = out_valid_r;
  assign out_ok         = out_ok_r;
  assign out_read_value = out_rv_r;
  assign out_cursor     = out_cur_r;
  assign out_high_mark  = out_mark_r;

endmodule

[sv/bbfe_chk.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bbfe_chk
// Port-level checks for the byte buffer field engine, bound to the top.
// ----------------------------------------------------------------------------
module bbfe_chk (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_valid,
  input logic                  in_stall,
  input logic                  out_valid,
  input logic                  out_stall,
  input logic                  out_ok,
  input logic [63:0]           out_read_value,
  input logic [bbfe_pkg::POS_W-1:0] out_cursor,
  input logic [bbfe_pkg::POS_W-1:0] out_high_mark
);

  import bbfe_pkg::*;

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_read_value) &&
                               $stable(out_cursor) && $stable(out_high_mark) &&
                               $stable(out_ok))
    else $error("result word changed under stall");

  // reset starts the store sweep, no word taken
  a_reset_sweep: assert property (@(posedge clk)
    !rst_n |=> in_stall && !out_valid)
    else $error("engine open right after reset");

  // positions never pass capacity
  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_cursor <= POS_W'(BUF_BYTES)) &&
                  (out_high_mark <= POS_W'(BUF_BYTES)))
    else $error("cursor or mark beyond capacity");

  // a refused word reads as zero
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ok |-> out_read_value == 64'd0)
    else $error("nonzero read value on failure");

endmodule

bind byte_buffer_field_engine_top bbfe_chk u_bbfe_chk (.*);
